// ===== rtl/est_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package est_pkg;

	localparam int DEF_POSITION_BITS = 16;
	localparam int FIELD_BITS = 16;

	localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_CARET = 8'h5E;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;

	typedef enum logic [3:0] {
		KIND_ID      = 4'd0,
		KIND_NUM     = 4'd1,
		KIND_PLUS    = 4'd2,
		KIND_MINUS   = 4'd3,
		KIND_STAR    = 4'd4,
		KIND_SLASH   = 4'd5,
		KIND_CARET   = 4'd6,
		KIND_LPAREN  = 4'd7,
		KIND_RPAREN  = 4'd8,
		KIND_INVALID = 4'd9,
		KIND_END     = 4'd10
	} kind_t;

	typedef enum logic [1:0] {
		CLS_LETTER = 2'd0,
		CLS_DIGIT  = 2'd1,
		CLS_SPACE  = 2'd2,
		CLS_OTHER  = 2'd3
	} cls_t;

	typedef enum logic [1:0] {
		MODE_IDLE   = 2'd0,
		MODE_IDENT  = 2'd1,
		MODE_NUMBER = 2'd2
	} mode_t;

	// One classified request handed from the front to the back.
	typedef struct packed {
		logic  is_end;
		cls_t  cls;
		kind_t op_kind;
	} cls_item_t;

	typedef struct packed {
		kind_t                 kind;
		logic [FIELD_BITS-1:0] start;
		logic [FIELD_BITS-1:0] len;
		logic                  end_flag;
	} token_t;

	function automatic cls_item_t classify(input logic command, input logic [7:0] c);
		cls_item_t r;
		r.is_end = command;
		r.op_kind = KIND_INVALID;
		if ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == CH_UNDERSCORE)
			r.cls = CLS_LETTER;
		else if (c >= 8'h30 && c <= 8'h39)
			r.cls = CLS_DIGIT;
		else if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D))
			r.cls = CLS_SPACE;
		else begin
			r.cls = CLS_OTHER;
			unique case (c)
				CH_PLUS:   r.op_kind = KIND_PLUS;
				CH_MINUS:  r.op_kind = KIND_MINUS;
				CH_STAR:   r.op_kind = KIND_STAR;
				CH_SLASH:  r.op_kind = KIND_SLASH;
				CH_CARET:  r.op_kind = KIND_CARET;
				CH_LPAREN: r.op_kind = KIND_LPAREN;
				CH_RPAREN: r.op_kind = KIND_RPAREN;
				default:   r.op_kind = KIND_INVALID;
			endcase
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/est_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module est_front import est_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	output logic           full,
	input  wire logic      command,
	input  wire logic [7:0] character,
	output logic           cls_valid,
	output cls_item_t      cls_item,
	input  wire logic      cls_take
);

	cls_item_t  buf_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_take;

	assign full = (count_q == 2'd2);
	assign do_push = push && !full;
	assign cls_valid = (count_q != 2'd0);
	assign do_take = cls_take && cls_valid;
	assign cls_item = buf_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			buf_q[wr_ptr_q] <= classify(command, character);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_push)
				wr_ptr_q <= ~wr_ptr_q;
			if (do_take)
				rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + {1'b0, do_push} - {1'b0, do_take};
		end
	end

endmodule
`default_nettype wire

// ===== rtl/est_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module est_back import est_pkg::*; #(
	parameter int POSITION_BITS = DEF_POSITION_BITS
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cls_valid,
	input  wire cls_item_t  cls_item,
	output logic            cls_take,
	output logic            empty,
	input  wire logic       pop,
	output token_t          head
);

	localparam int CntW = (POSITION_BITS < FIELD_BITS) ? POSITION_BITS : FIELD_BITS;
	localparam logic [CntW-1:0] CntMax = '1;

	mode_t           mode_q;
	logic [CntW-1:0] pos_q;
	logic [CntW-1:0] pstart_q;
	logic [CntW-1:0] plen_q;

	token_t     oq_q [4];
	logic [1:0] wr_ptr_q;
	logic [1:0] rd_ptr_q;
	logic [2:0] count_q;

	mode_t           mode_d;
	logic [CntW-1:0] pos_d;
	logic [CntW-1:0] pstart_d;
	logic [CntW-1:0] plen_d;
	logic            flush_v;
	logic            second_v;
	token_t          flush_tok;
	token_t          second_tok;
	token_t          tok0;
	token_t          tok1;
	logic [1:0]      n_tok;
	logic            do_pop;
	logic            extend;

	assign cls_take = cls_valid && (count_q <= 3'd2);
	assign empty = (count_q == 3'd0);
	assign do_pop = pop && !empty;
	assign head = oq_q[rd_ptr_q];

	always_comb begin
		mode_d = mode_q;
		pos_d = (pos_q == CntMax) ? pos_q : pos_q + 1'b1;
		pstart_d = pstart_q;
		plen_d = (plen_q == CntMax) ? plen_q : plen_q + 1'b1;
		flush_tok.kind = (mode_q == MODE_IDENT) ? KIND_ID : KIND_NUM;
		flush_tok.start = FIELD_BITS'(pstart_q);
		flush_tok.len = FIELD_BITS'(plen_q);
		flush_tok.end_flag = 1'b0;
		second_tok.kind = cls_item.op_kind;
		second_tok.start = FIELD_BITS'(pos_q);
		second_tok.len = FIELD_BITS'(1);
		second_tok.end_flag = 1'b0;
		flush_v = 1'b0;
		second_v = 1'b0;
		extend = ((mode_q == MODE_IDENT) &&
				(cls_item.cls == CLS_LETTER || cls_item.cls == CLS_DIGIT)) ||
			((mode_q == MODE_NUMBER) && (cls_item.cls == CLS_DIGIT));
		if (cls_item.is_end) begin
			flush_v = (mode_q == MODE_IDENT) || (mode_q == MODE_NUMBER);
			second_v = 1'b1;
			second_tok.kind = KIND_END;
			second_tok.len = '0;
			second_tok.end_flag = 1'b1;
			mode_d = MODE_IDLE;
			pos_d = '0;
			pstart_d = '0;
			plen_d = '0;
		end else if (!extend) begin
			flush_v = (mode_q == MODE_IDENT) || (mode_q == MODE_NUMBER);
			mode_d = MODE_IDLE;
			pstart_d = '0;
			plen_d = '0;
			unique case (cls_item.cls)
				CLS_LETTER: begin
					mode_d = MODE_IDENT;
					pstart_d = pos_q;
					plen_d = CntW'(1);
				end
				CLS_DIGIT: begin
					mode_d = MODE_NUMBER;
					pstart_d = pos_q;
					plen_d = CntW'(1);
				end
				CLS_SPACE: begin
				end
				default: second_v = 1'b1;
			endcase
		end
		tok0 = flush_v ? flush_tok : second_tok;
		tok1 = second_tok;
		n_tok = {1'b0, flush_v} + {1'b0, second_v};
		if (!cls_take)
			n_tok = 2'd0;
	end

	always_ff @(posedge clk) begin
		if (n_tok != 2'd0)
			oq_q[wr_ptr_q] <= tok0;
		if (n_tok == 2'd2)
			oq_q[wr_ptr_q + 2'd1] <= tok1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			pos_q <= '0;
			pstart_q <= '0;
			plen_q <= '0;
			wr_ptr_q <= 2'd0;
			rd_ptr_q <= 2'd0;
			count_q <= 3'd0;
		end else begin
			if (cls_take) begin
				mode_q <= mode_d;
				pos_q <= pos_d;
				pstart_q <= pstart_d;
				plen_q <= plen_d;
			end
			wr_ptr_q <= wr_ptr_q + n_tok;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 2'd1;
			count_q <= count_q + {1'b0, n_tok} - {2'b00, do_pop};
		end
	end

endmodule
`default_nettype wire

// ===== rtl/expression_token_scanner.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Byte-serial lexer for arithmetic expressions. Each request carries one byte or an
// end-of-input mark; a classifier front end feeds a two-entry queue, and the scanner back
// end keeps the identifier/number state and writes up to two tokens per request into a
// four-entry result queue. One request is taken per clock as long as results are popped;
// the back end waits only when the result queue has fewer than two free entries. Start
// position and length saturate at 2^POSITION_BITS - 1, capped at 65535, and the state
// clears after every end request.
module expression_token_scanner import est_pkg::*; #(
	parameter int POSITION_BITS = DEF_POSITION_BITS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic        command,
	input  wire logic [7:0]  character,
	output logic             empty,
	input  wire logic        pop,
	output logic [3:0]       token_kind,
	output logic [15:0]      start_position,
	output logic [15:0]      token_length,
	output logic             end_flag
);

	logic      cls_valid;
	logic      cls_take;
	cls_item_t cls_item;
	token_t    head;

	est_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.command   (command),
		.character (character),
		.cls_valid (cls_valid),
		.cls_item  (cls_item),
		.cls_take  (cls_take)
	);

	est_back #(
		.POSITION_BITS (POSITION_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cls_valid (cls_valid),
		.cls_item  (cls_item),
		.cls_take  (cls_take),
		.empty     (empty),
		.pop       (pop),
		.head      (head)
	);

	assign token_kind = head.kind;
	assign start_position = head.start;
	assign token_length = head.len;
	assign end_flag = head.end_flag;

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
	import est_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int MAX_SHOWN = 10;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int LONG_WORD = 40;
	localparam logic [15:0] POS_MAX = 16'hFFFF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic command = 1'b0;
	logic [7:0] character = 8'h00;
	logic pop = 1'b0;
	logic full;
	logic empty;
	logic [3:0] token_kind;
	logic [15:0] start_position;
	logic [15:0] token_length;
	logic end_flag;

	token_t awaited_tokens[$];
	mode_t lex_mode = MODE_IDLE;
	logic [15:0] lex_pos = '0;
	logic [15:0] lex_start = '0;
	logic [15:0] lex_len = '0;

	int errors = 0;
	int requests_sent = 0;
	int streams_sent = 0;
	int tokens_seen = 0;
	int hold_cycles = 0;
	bit tx_idle = 1'b0;
	bit rx_idle = 1'b0;

	expression_token_scanner i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.command(command),
		.character(character),
		.empty(empty),
		.pop(pop),
		.token_kind(token_kind),
		.start_position(start_position),
		.token_length(token_length),
		.end_flag(end_flag)
	);

	always #6 clk = ~clk;

	function automatic bit starts_word(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
			c == CH_UNDERSCORE;
	endfunction

	function automatic bit is_decimal(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic bit is_blank(input logic [7:0] c);
		return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic logic [15:0] sat_inc(input logic [15:0] v);
		return (v == POS_MAX) ? v : v + 16'd1;
	endfunction

	function automatic kind_t operator_kind(input logic [7:0] c);
		case (c)
			CH_PLUS:   return KIND_PLUS;
			CH_MINUS:  return KIND_MINUS;
			CH_STAR:   return KIND_STAR;
			CH_SLASH:  return KIND_SLASH;
			CH_CARET:  return KIND_CARET;
			CH_LPAREN: return KIND_LPAREN;
			CH_RPAREN: return KIND_RPAREN;
			default:   return KIND_INVALID;
		endcase
	endfunction

	function automatic int gap_length(input bit enabled);
		int r;
		r = $urandom_range(0, 99);
		if (!enabled || r < 70)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [7:0] word_head();
		int r;
		r = $urandom_range(0, 52);
		if (r < 26)
			return 8'h61 + 8'(r);
		if (r < 52)
			return 8'h41 + 8'(r - 26);
		return CH_UNDERSCORE;
	endfunction

	function automatic logic [7:0] word_tail();
		int r;
		r = $urandom_range(0, 62);
		if (r < 52)
			return word_head();
		if (r < 62)
			return 8'h30 + 8'(r - 52);
		return CH_UNDERSCORE;
	endfunction

	function automatic logic [7:0] decimal_digit();
		return 8'h30 + 8'($urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] pick_operator();
		case ($urandom_range(0, 6))
			0:       return CH_PLUS;
			1:       return CH_MINUS;
			2:       return CH_STAR;
			3:       return CH_SLASH;
			4:       return CH_CARET;
			5:       return CH_LPAREN;
			default: return CH_RPAREN;
		endcase
	endfunction

	function automatic logic [7:0] blank_char();
		int r;
		r = $urandom_range(8, 13);
		return (r == 8) ? 8'h20 : 8'(r);
	endfunction

	task automatic await_token(input kind_t k, input logic [15:0] s, input logic [15:0] l,
			input logic e);
		token_t t;
		t.kind = k;
		t.start = s;
		t.len = l;
		t.end_flag = e;
		awaited_tokens.insert(awaited_tokens.size(), t);
	endtask

	task automatic flush_pending();
		if (lex_mode == MODE_IDENT)
			await_token(KIND_ID, lex_start, lex_len, 1'b0);
		else if (lex_mode == MODE_NUMBER)
			await_token(KIND_NUM, lex_start, lex_len, 1'b0);
		lex_mode = MODE_IDLE;
		lex_start = '0;
		lex_len = '0;
	endtask

	task automatic scan_byte(input logic cmd, input logic [7:0] c);
		logic [15:0] p;
		p = lex_pos;
		if (cmd) begin
			flush_pending();
			await_token(KIND_END, p, 16'd0, 1'b1);
			lex_pos = '0;
		end else begin
			if (lex_mode == MODE_IDENT && (starts_word(c) || is_decimal(c)))
				lex_len = sat_inc(lex_len);
			else if (lex_mode == MODE_NUMBER && is_decimal(c))
				lex_len = sat_inc(lex_len);
			else begin
				flush_pending();
				if (starts_word(c)) begin
					lex_mode = MODE_IDENT;
					lex_start = p;
					lex_len = 16'd1;
				end else if (is_decimal(c)) begin
					lex_mode = MODE_NUMBER;
					lex_start = p;
					lex_len = 16'd1;
				end else if (!is_blank(c))
					await_token(operator_kind(c), p, 16'd1, 1'b0);
			end
			lex_pos = sat_inc(p);
		end
	endtask

	task automatic send_request(input logic cmd, input logic [7:0] c);
		int gap;
		push <= 1'b1;
		command <= cmd;
		character <= c;
		do @(posedge clk); while (full);
		scan_byte(cmd, c);
		requests_sent++;
		if (cmd)
			streams_sent++;
		gap = gap_length(tx_idle);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic release_sender();
		push <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_token();
		token_t want;
		tokens_seen++;
		if (awaited_tokens.size() == 0) begin
			errors++;
			if (errors <= MAX_SHOWN)
				$display("Unexpected token: kind %0d start %0d length %0d end %0b",
					token_kind, start_position, token_length, end_flag);
		end else begin
			want = awaited_tokens.pop_front();
			if (token_kind !== want.kind || start_position !== want.start ||
					token_length !== want.len || end_flag !== want.end_flag) begin
				errors++;
				if (errors <= MAX_SHOWN)
					$display({"Token mismatch: expected kind %0d start %0d length %0d ",
						"end %0b, actual kind %0d start %0d length %0d end %0b"},
						want.kind, want.start, want.len, want.end_flag,
						token_kind, start_position, token_length, end_flag);
			end
		end
	endtask

	task automatic test_directed();
		logic [7:0] text [0:24];
		text = '{CH_UNDERSCORE, "a", "9", CH_PLUS, CH_LPAREN, "0", "7", CH_RPAREN,
			CH_MINUS, "x", CH_STAR, "Z", CH_SLASH, 8'h20, CH_CARET,
			8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h00, 8'hFF, 8'h80, "1", "a"};
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		foreach (text[i])
			send_request(1'b0, text[i]);
		send_request(1'b1, 8'hFF);
		send_request(1'b1, 8'h00);
		release_sender();
	endtask

	task automatic send_stream();
		int words;
		int n;
		words = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) :
			$urandom_range(0, 10);
		repeat (words) begin
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					send_request(1'b0, word_head());
					n = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 24) :
						$urandom_range(0, 5);
					repeat (n) send_request(1'b0, word_tail());
				end
				3, 4: begin
					n = $urandom_range(1, 6);
					repeat (n) send_request(1'b0, decimal_digit());
				end
				5, 6, 7: send_request(1'b0, pick_operator());
				8: send_request(1'b0, blank_char());
				default: send_request(1'b0, 8'($urandom_range(0, 255)));
			endcase
			if ($urandom_range(0, 1) == 0)
				send_request(1'b0, blank_char());
		end
		send_request(1'b1, 8'($urandom_range(0, 255)));
	endtask

	task automatic test_random_streams();
		int first;
		first = requests_sent;
		while (requests_sent - first < 700) begin
			tx_idle = ($urandom_range(0, 3) != 0);
			rx_idle = ($urandom_range(0, 3) != 0);
			send_stream();
		end
		release_sender();
	endtask

	task automatic test_result_backpressure();
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		hold_cycles = HOLD_OFF_CYCLES;
		repeat (20) begin
			send_request(1'b0, word_head());
			send_request(1'b0, pick_operator());
			send_request(1'b0, decimal_digit());
		end
		send_request(1'b1, 8'h00);
		release_sender();
		while (hold_cycles > 0) @(posedge clk);
	endtask

	task automatic test_long_word();
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		send_request(1'b0, word_head());
		repeat (LONG_WORD) send_request(1'b0, word_tail());
		send_request(1'b0, CH_MINUS);
		send_request(1'b0, "4");
		send_request(1'b0, "2");
		send_request(1'b0, "q");
		send_request(1'b1, 8'h5A);
		release_sender();
	endtask

	initial begin : token_sink
		int stall;
		stall = 0;
		forever begin
			@(posedge clk);
			if (arst_n && pop && !empty)
				check_token();
			if (hold_cycles > 0) begin
				hold_cycles--;
				pop <= 1'b0;
			end else if (stall > 0) begin
				stall--;
				pop <= 1'b0;
			end else begin
				stall = gap_length(rx_idle);
				pop <= (stall == 0);
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty))
				quiet = 0;
			else
				quiet++;
		end
		$display("Timeout: nothing accepted for %0d cycles", quiet);
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_streams();
		test_result_backpressure();
		test_long_word();
		while (awaited_tokens.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("Sent %0d requests in %0d streams and checked %0d tokens.",
			requests_sent, streams_sent, tokens_seen);
		$display({"Covered every operator, blanks, invalid bytes, empty streams, ",
			"a long result stall and a long identifier."});
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
